FILE: rtl/cv3_pkg.sv
// ----------------------------------------------------------------------------
// cv3_pkg: shared types and constants of the 3x3 convolution filter
// Widths of pixels, coefficients, partial sums and stream words, register
// indexes and the column types that move along the window cell chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cv3_pkg;

  // Image geometry
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int MASK_SIZE  = 3;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  // Arithmetic widths
  localparam int PIX_W  = 8;
  localparam int COEF_W = 16;
  localparam int PROD_W = 24;
  localparam int CSUM_W = 26;
  localparam int SUM_W  = 28;

  // Configuration port
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 48;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_TOP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_MID     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_BOT     = 3'd4;

  localparam logic [CFG_DATA_W-1:0] MASK_TOP_RESET = 48'd0;
  localparam logic [CFG_DATA_W-1:0] MASK_MID_RESET = 48'd16777216;
  localparam logic [CFG_DATA_W-1:0] MASK_BOT_RESET = 48'd0;

  // Stream words
  localparam int S_TDATA_W = 8;
  localparam int M_TDATA_W = 56;

  // One column of the window: rows top to bottom
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } pix_col_t;

  // One column of the mask
  typedef struct packed {
    logic [COEF_W-1:0] top;
    logic [COEF_W-1:0] mid;
    logic [COEF_W-1:0] bot;
  } coef_col_t;

  // One line buffer entry: the two previous rows at a column
  typedef struct packed {
    logic [PIX_W-1:0] newer;
    logic [PIX_W-1:0] older;
  } line_pair_t;

  // Per-request control travelling down the pipeline
  typedef struct packed {
    logic             emit;
    logic             last;
    logic [ROW_W-1:0] orow;
    logic [COL_W-1:0] ocol;
  } meta_t;

endpackage

FILE: rtl/conv3x3_image_filter.sv
// ----------------------------------------------------------------------------
// conv3x3_image_filter: streaming 3x3 image convolution
// Line buffer, a chain of three window cells and an adder into the output
// register.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on s_tvalid/s_tready in raster order; s_tuser marks the
//   first pixel of a frame and clears the row and column counters. Results
//   leave on m_tvalid/m_tready, one per pixel whose 3x3 neighborhood lies
//   inside the image, i.e. (height-2) x (width-2) per frame; m_tlast marks
//   the last result of a frame. After the last pixel of a frame the next
//   pixel starts a new frame even without s_tuser.
//   Throughput is one pixel per clock while the receiver does not stall. A
//   result passes through the line buffer read, window shift, multiply,
//   column sum and final add, each one register stage, the first loaded
//   at the edge that accepts its pixel.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and s_tready falls in the same cycle; a request is taken whenever the
//   output register is empty or being drained.
//   Reset clears the counters, window and pipeline, loads width and height
//   1024 and a centre-only mask of 256. Configuration writes (cfg_wr_en,
//   cfg_index, cfg_data) must be issued only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module conv3x3_image_filter (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration write port
  input  logic                                cfg_wr_en,
  input  logic [cv3_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cv3_pkg::CFG_DATA_W-1:0]      cfg_data,
  // Pixel input
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [cv3_pkg::S_TDATA_W-1:0]       s_tdata,  // [7:0] pixel
  input  logic                                s_tuser,  // frame_start
  // Result output
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [27:0] filtered, [39:28] out_row, [49:40] out_col, [55:50] zero
  output logic [cv3_pkg::M_TDATA_W-1:0]       m_tdata,
  output logic                                m_tlast   // frame_done
);
  import cv3_pkg::*;

  // Configuration registers
  logic [COL_W-1:0]      width_m1;
  logic [ROW_W-1:0]      height_m1;
  logic [CFG_DATA_W-1:0] mask_top;
  logic [CFG_DATA_W-1:0] mask_mid;
  logic [CFG_DATA_W-1:0] mask_bot;
  logic [WIDTH_REG_W-1:0]  cfg_w;
  logic [HEIGHT_REG_W-1:0] cfg_h;

  // Position counters
  logic [COL_W-1:0] column_position;
  logic [ROW_W-1:0] row_position;
  logic [COL_W-1:0] cpos;
  logic [ROW_W-1:0] rpos;
  logic [COL_W-1:0] col0;
  logic [ROW_W-1:0] row0;
  logic [COL_W-1:0] column_position_next;
  logic [ROW_W-1:0] row_position_next;
  meta_t            meta0;

  // Pipeline
  logic             en;
  logic             accept;
  logic             v1, v2, v3, v4;
  meta_t            meta1, meta2, meta3, meta4;
  logic [PIX_W-1:0] px1;
  logic [COL_W-1:0] col1;
  line_pair_t       lb_rd;
  line_pair_t       lb_wr;
  logic             lb_wr_en;

  // Cell chain
  pix_col_t                 chain [MASK_SIZE+1];
  coef_col_t                coefs [MASK_SIZE];
  logic signed [CSUM_W-1:0] csum  [MASK_SIZE];
  logic signed [SUM_W-1:0]  total;

  logic [SUM_W-1:0] out_filtered;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;

  // Configuration writes: store sizes clamped and minus one
  assign cfg_w = cfg_data[WIDTH_REG_W-1:0];
  assign cfg_h = cfg_data[HEIGHT_REG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      width_m1  <= COL_W'(MAX_WIDTH - 1);
      height_m1 <= ROW_W'(1024 - 1);
      mask_top  <= MASK_TOP_RESET;
      mask_mid  <= MASK_MID_RESET;
      mask_bot  <= MASK_BOT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH: begin
          if (cfg_w < WIDTH_REG_W'(MASK_SIZE)) begin
            width_m1 <= COL_W'(MASK_SIZE - 1);
          end else if (cfg_w > WIDTH_REG_W'(MAX_WIDTH)) begin
            width_m1 <= COL_W'(MAX_WIDTH - 1);
          end else begin
            width_m1 <= COL_W'(cfg_w - 1'b1);
          end
        end
        REG_IMAGE_HEIGHT: begin
          if (cfg_h < HEIGHT_REG_W'(MASK_SIZE)) begin
            height_m1 <= ROW_W'(MASK_SIZE - 1);
          end else if (cfg_h > HEIGHT_REG_W'(MAX_HEIGHT)) begin
            height_m1 <= ROW_W'(MAX_HEIGHT - 1);
          end else begin
            height_m1 <= ROW_W'(cfg_h - 1'b1);
          end
        end
        REG_MASK_TOP: mask_top <= cfg_data;
        REG_MASK_MID: mask_mid <= cfg_data;
        REG_MASK_BOT: mask_bot <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the pipeline whenever the output register can take a result
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign accept   = s_tvalid && s_tready;

  // Position of the incoming pixel, held inside the current frame size
  always_comb begin
    cpos = s_tuser ? '0 : column_position;
    rpos = s_tuser ? '0 : row_position;
    col0 = (cpos > width_m1) ? width_m1 : cpos;
    row0 = (rpos > height_m1) ? height_m1 : rpos;

    meta0.emit = (row0 >= ROW_W'(2)) && (col0 >= COL_W'(2));
    meta0.last = (row0 == height_m1) && (col0 == width_m1);
    meta0.orow = row0 - ROW_W'(2);
    meta0.ocol = col0 - COL_W'(2);

    if (col0 >= width_m1) begin
      column_position_next = '0;
      row_position_next    = (row0 >= height_m1) ? '0 : row0 + 1'b1;
    end else begin
      column_position_next = col0 + 1'b1;
      row_position_next    = row0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      row_position    <= '0;
    end else if (accept) begin
      column_position <= column_position_next;
      row_position    <= row_position_next;
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      v4       <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      v1       <= s_tvalid;
      v2       <= v1;
      v3       <= v2;
      v4       <= v3;
      m_tvalid <= v4 && meta4.emit;
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (en) begin
      px1   <= s_tdata[PIX_W-1:0];
      col1  <= col0;
      meta1 <= meta0;
      meta2 <= meta1;
      meta3 <= meta2;
      meta4 <= meta3;
    end
  end

  // Line buffer: read at the new column, write the shifted pair back
  assign lb_wr_en    = en && v1;
  assign lb_wr.older = lb_rd.newer;
  assign lb_wr.newer = px1;

  cv3_line_buf u_line_buf (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .rd_addr (col0),
    .wr_en   (lb_wr_en),
    .wr_addr (col1),
    .wr_data (lb_wr),
    .rd_data (lb_rd)
  );

  // Newest column enters the rightmost cell
  assign chain[MASK_SIZE].top = lb_rd.older;
  assign chain[MASK_SIZE].mid = lb_rd.newer;
  assign chain[MASK_SIZE].bot = px1;

  for (genvar i = 0; i < MASK_SIZE; i++) begin : g_cell
    assign coefs[i].top = mask_top[COEF_W*i +: COEF_W];
    assign coefs[i].mid = mask_mid[COEF_W*i +: COEF_W];
    assign coefs[i].bot = mask_bot[COEF_W*i +: COEF_W];

    cv3_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .shift   (lb_wr_en),
      .pix_in  (chain[i+1]),
      .coef    (coefs[i]),
      .pix_out (chain[i]),
      .col_sum (csum[i])
    );
  end

  // Final add of the three column sums
  assign total = SUM_W'(csum[0]) + SUM_W'(csum[1]) + SUM_W'(csum[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      out_filtered <= total;
      out_row      <= meta4.orow;
      out_col      <= meta4.ocol;
      m_tlast      <= meta4.last;
    end
  end

  assign m_tdata = {(M_TDATA_W - SUM_W - ROW_W - COL_W)'(0), out_col, out_row, out_filtered};

  // A frame start pixel always leaves the counters at row 0, column 1
  assert property (@(posedge clk) disable iff (rst)
    accept && s_tuser |=> column_position == COL_W'(1) && row_position == '0)
    else $error("frame start did not restart the counters");

  // A stalled receiver freezes every stage
  assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(v1) && $stable(v2) && $stable(v3) && $stable(v4))
    else $error("pipeline moved during a stall");

  // A colliding line buffer read returns the pair just written
  assert property (@(posedge clk) disable iff (rst)
    lb_wr_en && col0 == col1 |=> lb_rd === $past(lb_wr))
    else $error("line buffer forwarding lost a write");

  // An emitting request at the last stage reaches the output register
  assert property (@(posedge clk) disable iff (rst)
    en && v4 && meta4.emit |=> m_tvalid)
    else $error("result dropped before the output register");

endmodule

FILE: rtl/cv3_line_buf.sv
// ----------------------------------------------------------------------------
// cv3_line_buf: two-row line buffer
// One memory holds both previous rows per column. Read data is registered;
// a write to the address read in the same cycle is forwarded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cv3_line_buf (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic [cv3_pkg::COL_W-1:0]   rd_addr,
  input  logic                        wr_en,
  input  logic [cv3_pkg::COL_W-1:0]   wr_addr,
  input  cv3_pkg::line_pair_t         wr_data,
  output cv3_pkg::line_pair_t         rd_data
);
  import cv3_pkg::*;

  line_pair_t mem [MAX_WIDTH];
  line_pair_t rd_q;
  line_pair_t byp_data;
  logic       byp;

  // Write the new pair, read the next column
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (en) begin
      rd_q     <= mem[rd_addr];
      byp_data <= wr_data;
    end
  end

  // Track a read that collided with the write of the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      byp <= 1'b0;
    end else if (en) begin
      byp <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = byp ? byp_data : rd_q;

endmodule

FILE: rtl/cv3_cell.sv
// ----------------------------------------------------------------------------
// cv3_cell: one window column cell
// Holds one column of the 3x3 window, hands it to its left neighbor on each
// pixel, and multiplies it by its mask column into a registered column sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cv3_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        shift,
  input  cv3_pkg::pix_col_t           pix_in,
  input  cv3_pkg::coef_col_t          coef,
  output cv3_pkg::pix_col_t           pix_out,
  output logic signed [cv3_pkg::CSUM_W-1:0] col_sum
);
  import cv3_pkg::*;

  pix_col_t                 pix;
  logic signed [PROD_W:0]   mul_top;
  logic signed [PROD_W:0]   mul_mid;
  logic signed [PROD_W:0]   mul_bot;
  logic signed [PROD_W-1:0] prod_top;
  logic signed [PROD_W-1:0] prod_mid;
  logic signed [PROD_W-1:0] prod_bot;

  // Shift the window column in from the right neighbor
  always_ff @(posedge clk) begin
    if (rst) begin
      pix <= '0;
    end else if (shift) begin
      pix <= pix_in;
    end
  end

  assign pix_out = pix;

  // Unsigned pixel times signed coefficient
  assign mul_top = $signed({1'b0, pix.top}) * $signed(coef.top);
  assign mul_mid = $signed({1'b0, pix.mid}) * $signed(coef.mid);
  assign mul_bot = $signed({1'b0, pix.bot}) * $signed(coef.bot);

  // Register products, then the column sum
  always_ff @(posedge clk) begin
    if (en) begin
      prod_top <= mul_top[PROD_W-1:0];
      prod_mid <= mul_mid[PROD_W-1:0];
      prod_bot <= mul_bot[PROD_W-1:0];
      col_sum  <= CSUM_W'(prod_top) + CSUM_W'(prod_mid) + CSUM_W'(prod_bot);
    end
  end

endmodule
